[hw/rtl/psrl_pkg.sv]
// Shared types, codes and sizes for the per-source rate limiter with blocklist.
// No dependencies; psrl_cam, psrl_front, psrl_back, the top level and the checker import this package.
package psrl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CFG_IDX_W     = 3;

    // Frame classes
    localparam logic [1:0] KIND_MALFORMED = 2'd0;
    localparam logic [1:0] KIND_NOT_IP    = 2'd1;
    localparam logic [1:0] KIND_IPV4      = 2'd2;
    localparam logic [1:0] KIND_IPV6      = 2'd3;

    // Verdict codes
    localparam logic [2:0] VERD_PASS      = 3'd0;
    localparam logic [2:0] VERD_MALFORMED = 3'd1;
    localparam logic [2:0] VERD_BLOCKED   = 3'd2;
    localparam logic [2:0] VERD_OVER      = 3'd3;
    localparam logic [2:0] VERD_CLASSIFY  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PKT_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DUR  = 3'd3;

    localparam logic [63:0] RST_WINDOW_LEN = 64'd1000000000;
    localparam logic [31:0] RST_PKT_LIMIT  = 32'd1000;
    localparam logic [47:0] RST_BYTE_LIMIT = 48'd125000000;
    localparam logic [63:0] RST_BLOCK_DUR  = 64'd10000000000;

    localparam logic [31:0] MAX_PKTS  = '1;
    localparam logic [47:0] MAX_BYTES = '1;

    typedef struct packed {
        logic        is6;
        logic [63:0] hi;
        logic [63:0] lo;
    } key_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] now;
        key_t        key;
        logic [15:0] len;
    } item_t;

    typedef struct packed {
        logic [63:0] wstart;
        logic [47:0] bytes;
        logic [31:0] packets;
    } rate_rec_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [63:0]          data;
    } cfg_wr_t;

    // Update request for one associative table
    typedef struct packed {
        logic             write_en;
        logic             inval_en;
        logic             promote_en;
        logic [IDX_W-1:0] idx;
    } cam_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_LIM  = 5'b01000,
        ST_DONE = 5'b10000
    } back_state_t;

endpackage

[hw/rtl/psrl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/psrl_cam.sv]
// Fully associative key table with valid bits and LRU ranks.
// Depends on psrl_pkg.
module psrl_cam import psrl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  key_t             key,
    input  cam_ctl_t         ctl,
    output logic             hit,
    output logic [IDX_W-1:0] hit_idx,
    output logic [IDX_W-1:0] victim_idx
);

    logic             valid_reg [TABLE_ENTRIES];
    key_t             key_reg   [TABLE_ENTRIES];
    logic [IDX_W-1:0] age_reg   [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] match;
    logic                     any_free;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         lru_idx;
    logic [IDX_W-1:0]         age_sel;

    // Match lines and priority encoders (lowest index wins)
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        any_free = 1'b0;
        for (int j = TABLE_ENTRIES - 1; j >= 0; j--)
        begin
            match[j] = valid_reg[j] && (key_reg[j] == key);
            if (match[j])
            begin
                hit_idx = IDX_W'(j);
            end
            if (!valid_reg[j])
            begin
                free_idx = IDX_W'(j);
                any_free = 1'b1;
            end
            if (age_reg[j] == IDX_W'(TABLE_ENTRIES - 1))
            begin
                lru_idx = IDX_W'(j);
            end
        end
        hit        = |match;
        victim_idx = any_free ? free_idx : lru_idx;
        age_sel    = age_reg[ctl.idx];
    end

    // Valid bits and ranks; ranks stay a permutation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TABLE_ENTRIES; j++)
            begin
                valid_reg[j] <= 1'b0;
                age_reg[j]   <= IDX_W'(j);
            end
        end
        else
        begin
            if (ctl.write_en)
            begin
                valid_reg[ctl.idx] <= 1'b1;
            end
            if (ctl.inval_en)
            begin
                valid_reg[ctl.idx] <= 1'b0;
            end
            if (ctl.promote_en)
            begin
                for (int j = 0; j < TABLE_ENTRIES; j++)
                begin
                    if (IDX_W'(j) == ctl.idx)
                    begin
                        age_reg[j] <= '0;
                    end
                    else if (age_reg[j] < age_sel)
                    begin
                        age_reg[j] <= age_reg[j] + 1'b1;
                    end
                end
            end
        end
    end

    // Stored keys
    always_ff @(posedge clk)
    begin
        if (ctl.write_en)
        begin
            key_reg[ctl.idx] <= key;
        end
    end

endmodule

[hw/rtl/psrl_front.sv]
// Front end: accepts frames, normalizes the source key, queues two items.
// Depends on psrl_pkg.
module psrl_front import psrl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] now_ns,
    input  logic [63:0] source_high,
    input  logic [63:0] source_low,
    input  logic [15:0] frame_length,
    input  logic        q_pop,
    output logic        q_empty,
    output item_t       q_item
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      in_item;
    logic       push;

    // Classify: IPv4 keys keep only the low 32 bits
    always_comb
    begin
        in_item.kind    = kind;
        in_item.now     = now_ns;
        in_item.len     = frame_length;
        in_item.key.is6 = (kind == KIND_IPV6);
        in_item.key.hi  = (kind == KIND_IPV6) ? source_high : '0;
        in_item.key.lo  = (kind == KIND_IPV6) ? source_low : {32'd0, source_low[31:0]};
    end

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign q_empty    = (count_reg == 2'd0);
    assign q_item     = slot_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hw/rtl/psrl_back.sv]
// Back end: blocklist and rate table sequencer, config registers, result register.
// Depends on psrl_pkg, psrl_cam and psrl_ram.
module psrl_back import psrl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_wr_t     cfg,
    input  logic        q_empty,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  verdict,
    output logic [31:0] window_packets,
    output logic [47:0] window_bytes,
    output logic [63:0] dropped_total
);

    back_state_t state_reg, state_next;
    item_t       cur_reg, cur_next;

    logic [63:0] wlen_reg, dur_reg;
    logic [31:0] plim_reg;
    logic [47:0] blim_reg;

    logic             b_hit_reg, r_hit_reg;
    logic [IDX_W-1:0] b_idx_reg, r_idx_reg, r_vict_reg;
    logic [31:0]      pk_reg, pk_next;
    logic [47:0]      by_reg, by_next;
    logic [2:0]       verd_reg, verd_next;
    logic [63:0]      drop_reg, drop_next;

    logic        res_valid_reg, res_valid_next;
    logic [2:0]  res_verd_reg;
    logic [31:0] res_pk_reg;
    logic [47:0] res_by_reg;
    logic [63:0] res_drop_reg;
    logic        res_load;

    logic             rc_hit, bc_hit;
    logic [IDX_W-1:0] rc_idx, rc_vict, bc_idx, bc_vict;
    cam_ctl_t         rctl, bctl;

    logic             r_we, b_we;
    logic [IDX_W-1:0] r_waddr, b_waddr;
    rate_rec_t        r_wdata, r_rdata;
    logic [63:0]      b_wdata, b_rdata;

    logic        blk_expired, blocked, over;
    logic [63:0] elapsed;
    logic [48:0] byte_sum;
    logic [IDX_W-1:0] r_sel;

    psrl_cam u_rate_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (cur_reg.key),
        .ctl        (rctl),
        .hit        (rc_hit),
        .hit_idx    (rc_idx),
        .victim_idx (rc_vict)
    );

    psrl_cam u_block_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (cur_reg.key),
        .ctl        (bctl),
        .hit        (bc_hit),
        .hit_idx    (bc_idx),
        .victim_idx (bc_vict)
    );

    psrl_ram #(.WIDTH($bits(rate_rec_t)), .DEPTH(TABLE_ENTRIES)) u_rate_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (rc_idx),
        .rdata (r_rdata)
    );

    psrl_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_block_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (bc_idx),
        .rdata (b_rdata)
    );

    assign res_load = (state_reg == ST_DONE) && !(res_valid_reg && result_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        pk_next    = pk_reg;
        by_next    = by_reg;
        verd_next  = verd_reg;
        drop_next  = drop_reg;
        q_pop      = 1'b0;
        rctl       = '0;
        bctl       = '0;
        r_we       = 1'b0;
        r_waddr    = r_idx_reg;
        r_wdata    = r_rdata;
        b_we       = 1'b0;
        b_waddr    = bc_idx;
        b_wdata    = cur_reg.now + dur_reg;
        elapsed    = cur_reg.now - r_rdata.wstart;
        byte_sum   = {1'b0, r_rdata.bytes} + {33'd0, cur_reg.len};
        r_sel      = r_hit_reg ? r_idx_reg : r_vict_reg;
        blk_expired = b_hit_reg && (b_rdata != '0) && (cur_reg.now > b_rdata);
        blocked     = b_hit_reg && !blk_expired && (b_rdata != '0);
        over        = (pk_reg > plim_reg) || (by_reg > blim_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    pk_next  = '0;
                    by_next  = '0;
                    case (q_item.kind)
                        KIND_MALFORMED:
                        begin
                            verd_next  = VERD_MALFORMED;
                            state_next = ST_DONE;
                        end
                        KIND_NOT_IP:
                        begin
                            verd_next  = VERD_PASS;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_LOOK;
                        end
                    endcase
                end
            end

            // Both lookups; RAM reads issue at the match indexes
            ST_LOOK:
            begin
                state_next = ST_EVAL;
            end

            // Blocklist decision, then counter update
            ST_EVAL:
            begin
                bctl.idx        = b_idx_reg;
                bctl.inval_en   = blk_expired;
                bctl.promote_en = b_hit_reg && !blk_expired;
                if (blocked)
                begin
                    drop_next  = drop_reg + 64'd1;
                    verd_next  = VERD_BLOCKED;
                    state_next = ST_DONE;
                end
                else
                begin
                    r_we            = 1'b1;
                    r_waddr         = r_sel;
                    rctl.idx        = r_sel;
                    rctl.promote_en = 1'b1;
                    if (r_hit_reg)
                    begin
                        if (elapsed > wlen_reg)
                        begin
                            r_wdata = '{wstart: cur_reg.now, bytes: '0, packets: '0};
                            pk_next = '0;
                            by_next = '0;
                        end
                        else
                        begin
                            r_wdata.packets = (r_rdata.packets == MAX_PKTS) ?
                                              MAX_PKTS : r_rdata.packets + 32'd1;
                            r_wdata.bytes   = byte_sum[48] ? MAX_BYTES : byte_sum[47:0];
                            pk_next = r_wdata.packets;
                            by_next = r_wdata.bytes;
                        end
                    end
                    else
                    begin
                        rctl.write_en = 1'b1;
                        r_wdata = '{wstart: cur_reg.now, bytes: {32'd0, cur_reg.len},
                                    packets: 32'd1};
                        pk_next = 32'd1;
                        by_next = {32'd0, cur_reg.len};
                    end
                    state_next = ST_LIM;
                end
            end

            // Limit check; an offender is (re)entered in the blocklist
            ST_LIM:
            begin
                if (over)
                begin
                    b_waddr         = bc_hit ? bc_idx : bc_vict;
                    b_we            = 1'b1;
                    bctl.idx        = b_waddr;
                    bctl.write_en   = 1'b1;
                    bctl.promote_en = 1'b1;
                    drop_next       = drop_reg + 64'd1;
                    verd_next       = VERD_OVER;
                end
                else
                begin
                    verd_next = VERD_CLASSIFY;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg && result_stall;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drop_reg      <= '0;
            res_valid_reg <= 1'b0;
            wlen_reg      <= RST_WINDOW_LEN;
            plim_reg      <= RST_PKT_LIMIT;
            blim_reg      <= RST_BYTE_LIMIT;
            dur_reg       <= RST_BLOCK_DUR;
        end
        else
        begin
            state_reg     <= state_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_WINDOW_LEN: wlen_reg <= cfg.data;
                    REG_PKT_LIMIT:  plim_reg <= cfg.data[31:0];
                    REG_BYTE_LIMIT: blim_reg <= cfg.data[47:0];
                    REG_BLOCK_DUR:  dur_reg  <= cfg.data;
                    default:        ;
                endcase
            end
        end
    end

    // Working item and datapath
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pk_reg   <= pk_next;
        by_reg   <= by_next;
        verd_reg <= verd_next;
        if (state_reg == ST_LOOK)
        begin
            b_hit_reg  <= bc_hit;
            b_idx_reg  <= bc_idx;
            r_hit_reg  <= rc_hit;
            r_idx_reg  <= rc_idx;
            r_vict_reg <= rc_vict;
        end
        if (res_load)
        begin
            res_verd_reg <= verd_reg;
            res_pk_reg   <= pk_reg;
            res_by_reg   <= by_reg;
            res_drop_reg <= drop_reg;
        end
    end

    assign result_valid   = res_valid_reg;
    assign verdict        = res_verd_reg;
    assign window_packets = res_pk_reg;
    assign window_bytes   = res_by_reg;
    assign dropped_total  = res_drop_reg;

endmodule

[hw/rtl/per_source_rate_limiter_blocklist.sv]
// Top level of the per-source rate limiter with blocklist.
// Depends on psrl_pkg, psrl_front, psrl_back.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------------
//  item     | item_valid/item_stall | kind, now_ns, source_high, source_low, frame_length
//  result   | result_valid/stall    | verdict, window_packets, window_bytes, dropped_total
//  config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An IP frame passes through the back end in order: pick up, table lookup, RAM read and
// counter update, limit check and blocklist write, result load; an IP frame dropped
// by the blocklist skips the limit check; malformed and non-IP frames go straight from
// pick up to result load. The sequencer handles one frame at a time; a two-entry queue
// in front keeps accepting transfers while it works, until full. Reset is asynchronous
// and clears both tables' valid bits at once. A stalled result holds the back end.
module per_source_rate_limiter_blocklist import psrl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           kind,
    input  logic [63:0]          now_ns,
    input  logic [63:0]          source_high,
    input  logic [63:0]          source_low,
    input  logic [15:0]          frame_length,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [2:0]           verdict,
    output logic [31:0]          window_packets,
    output logic [47:0]          window_bytes,
    output logic [63:0]          dropped_total,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic    q_pop, q_empty;
    item_t   q_item;
    cfg_wr_t cfg;

    // Config writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    psrl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .now_ns       (now_ns),
        .source_high  (source_high),
        .source_low   (source_low),
        .frame_length (frame_length),
        .q_pop        (q_pop),
        .q_empty      (q_empty),
        .q_item       (q_item)
    );

    psrl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .verdict        (verdict),
        .window_packets (window_packets),
        .window_bytes   (window_bytes),
        .dropped_total  (dropped_total)
    );

endmodule

[hw/rtl/psrl_checker.sv]
// Port-level checks for the rate limiter top level, bound in below.
// Depends on psrl_pkg.
module psrl_checker import psrl_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic [2:0]           verdict,
    input logic [31:0]          window_packets,
    input logic [47:0]          window_bytes,
    input logic [63:0]          dropped_total
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> verdict <= VERD_CLASSIFY)
        else $error("verdict code out of range");

    // Verdicts without counting report zero counters
    a_nocount: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict == VERD_PASS || verdict == VERD_MALFORMED ||
                         verdict == VERD_BLOCKED)
        |-> window_packets == '0 && window_bytes == '0)
        else $error("counters reported on uncounted verdict");

    // Over limit means some counter is above a limit, so it is nonzero
    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && verdict == VERD_OVER
        |-> window_packets != '0 || window_bytes != '0)
        else $error("over-limit verdict with zero counters");

    // A stalled result keeps its drop count
    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(dropped_total))
        else $error("dropped_total changed while stalled");

endmodule

bind per_source_rate_limiter_blocklist psrl_checker u_psrl_checker (.*);
